// ===== design/spr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types, widths and helpers for the sphere push-back resolver.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int SPR_COORD_W     = 32;
    localparam int SPR_RAD_W       = 31;
    localparam int SPR_WGT_W       = 16;
    localparam int SPR_MAG_W       = 32;
    localparam int SPR_SQ_W        = 64;
    localparam int SPR_SUM_W       = 66;
    localparam int SPR_ROOT_W      = 34;
    localparam int SPR_RSUM_W      = 32;
    localparam int SPR_WSUM_W      = 17;
    localparam int SPR_QUO_W       = 32;
    localparam int SPR_AMT_NUM_W   = SPR_RSUM_W + SPR_WGT_W;
    localparam int SPR_AXIS_NUM_W  = SPR_MAG_W + SPR_QUO_W;
    localparam int SPR_QUEUE_DEPTH = 4;

    typedef logic signed [SPR_COORD_W-1:0] t_coord;
    typedef logic [SPR_RAD_W-1:0]          t_rad;
    typedef logic [SPR_WGT_W-1:0]          t_wgt;
    typedef logic [SPR_MAG_W-1:0]          t_mag;

    // side data carried alongside the distance pipeline
    typedef struct packed {
        t_coord [2:0]          a;
        t_coord [2:0]          b;
        logic   [2:0]          neg;
        t_mag   [2:0]          mag;
        logic [SPR_RSUM_W-1:0] rsum;
        t_wgt                  wa;
        t_wgt                  wb;
    } t_fside;

    // classified item handed from front to back
    typedef struct packed {
        t_coord [2:0]          a;
        t_coord [2:0]          b;
        logic   [2:0]          neg;
        t_mag   [2:0]          mag;
        logic [SPR_ROOT_W-1:0] cdist;
        logic [SPR_RSUM_W-1:0] over;
        t_wgt                  wa;
        t_wgt                  wb;
        logic                  hit;
        logic                  werr;
        logic                  move;
    } t_job;

    function automatic t_coord spr_sat(input logic signed [SPR_COORD_W+1:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[SPR_COORD_W-1:0];
        end
    endfunction

endpackage

// ===== design/spr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_in_if
// Sphere pair channel: valid/ready plus both spheres.
// ----------------------------------------------------------------------------
interface spr_in_if;
    import spr_pkg::*;

    logic   valid;
    logic   ready;
    t_coord a_x;
    t_coord a_y;
    t_coord a_z;
    t_rad   a_radius;
    t_wgt   a_weight;
    t_coord b_x;
    t_coord b_y;
    t_coord b_z;
    t_rad   b_radius;
    t_wgt   b_weight;

    modport source (
        output valid, a_x, a_y, a_z, a_radius, a_weight,
               b_x, b_y, b_z, b_radius, b_weight,
        input  ready
    );
    modport sink (
        input  valid, a_x, a_y, a_z, a_radius, a_weight,
               b_x, b_y, b_z, b_radius, b_weight,
        output ready
    );
endinterface

// ===== design/spr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_out_if
// Result channel: valid/ready plus pushed centres and flags.
// ----------------------------------------------------------------------------
interface spr_out_if;
    import spr_pkg::*;

    logic   valid;
    logic   ready;
    t_coord new_a_x;
    t_coord new_a_y;
    t_coord new_a_z;
    t_coord new_b_x;
    t_coord new_b_y;
    t_coord new_b_z;
    logic   hit;
    logic   weight_error;

    modport source (
        output valid, new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z,
               hit, weight_error,
        input  ready
    );
    modport sink (
        input  valid, new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z,
               hit, weight_error,
        output ready
    );
endinterface

// ===== design/sphere_pushback_resolver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_pushback_resolver
// Resolves one sphere pair per item: distance, overlap test and weighted
// push-back of both centres.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  i_pair    in   valid/ready   a_x a_y a_z a_radius a_weight, b_* likewise
//  o_res     out  valid/ready   new_a_* new_b_* hit weight_error
//
//  one item per cycle sustained while the output is not stalled; an item
//  passes the front (3 + 34 root stages), the queue and the back (1 + 32
//  divider stages + 1 + 32 divider stages + output register) in that order
//  a full queue stalls only the front, a stalled output only the back
//  synchronous active-low reset clears all valid bits and the queue
// ----------------------------------------------------------------------------
module sphere_pushback_resolver #(
    parameter int QUEUE_DEPTH = spr_pkg::SPR_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spr_in_if.sink    i_pair,
    spr_out_if.source o_res
);
    import spr_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_job q_in_job;
    t_job q_out_job;

    spr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pair   (i_pair),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_in_job)
    );

    spr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_empty (q_empty)
    );

    spr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_job   (q_out_job),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

// ===== design/spr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_div
// Pipelined restoring divider, one quotient bit per stage; quotient must fit
// in QUO_W bits.
// ----------------------------------------------------------------------------
module spr_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 17,
    parameter int QUO_W = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);
    localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [NUM_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        localparam int BIT = QUO_W - 1 - s;
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [CMP_W-1:0] trial;
        logic             take;

        if (s == 0) begin : g_head
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_tail
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        assign trial = CMP_W'(den_in) << BIT;
        assign take  = CMP_W'(rem_in) >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= den_in;
                r_rem[s] <= take ? rem_in - trial[NUM_W-1:0] : rem_in;
                r_quo[s] <= take ? (quo_in | (QUO_W'(1) << BIT)) : quo_in;
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

// ===== design/spr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module spr_queue #(
    parameter int DEPTH = spr_pkg::SPR_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  spr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output spr_pkg::t_job o_job,
    output logic          o_empty
);
    import spr_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rd];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

// ===== design/spr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_front
// Centre distance (difference, squares, pipelined square root) and hit
// classification; pushes one job per pair into the queue.
// ----------------------------------------------------------------------------
module spr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spr_in_if.sink        i_pair,
    input  logic          i_q_full,
    output logic          o_q_push,
    output spr_pkg::t_job o_q_job
);
    import spr_pkg::*;

    localparam int LAST    = SPR_ROOT_W - 1;
    localparam int TRIAL_W = 2 * SPR_ROOT_W + 2;

    logic                  f_en;
    t_fside                n_s1;
    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;
    t_fside                r_s1;
    t_fside                r_s2;
    t_fside                r_s3;
    logic [SPR_SQ_W-1:0]   r_sq [3];
    logic [SPR_SUM_W-1:0]  r_sum;
    logic [LAST:0]         r_qv;
    t_fside                r_qs   [SPR_ROOT_W];
    logic [SPR_SUM_W-1:0]  r_rem  [SPR_ROOT_W];
    logic [SPR_ROOT_W-1:0] r_root [SPR_ROOT_W];

    // whole front advances unless a finished item is blocked by a full queue
    assign f_en         = !r_qv[LAST] || !i_q_full;
    assign i_pair.ready = f_en;

    always_comb begin
        logic [SPR_COORD_W:0] d;
        n_s1.a[0] = i_pair.a_x;
        n_s1.a[1] = i_pair.a_y;
        n_s1.a[2] = i_pair.a_z;
        n_s1.b[0] = i_pair.b_x;
        n_s1.b[1] = i_pair.b_y;
        n_s1.b[2] = i_pair.b_z;
        for (int i = 0; i < 3; i++) begin
            d = {n_s1.a[i][SPR_COORD_W-1], n_s1.a[i]} - {n_s1.b[i][SPR_COORD_W-1], n_s1.b[i]};
            n_s1.neg[i] = d[SPR_COORD_W];
            n_s1.mag[i] = d[SPR_COORD_W] ? SPR_MAG_W'(-d) : d[SPR_MAG_W-1:0];
        end
        n_s1.rsum = SPR_RSUM_W'(i_pair.a_radius) + SPR_RSUM_W'(i_pair.b_radius);
        n_s1.wa   = i_pair.a_weight;
        n_s1.wb   = i_pair.b_weight;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_qv <= '0;
        end else if (f_en) begin
            r_v1 <= i_pair.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_qv <= {r_qv[LAST-1:0], r_v3};
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_s1 <= n_s1;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= SPR_SQ_W'(r_s1.mag[i]) * SPR_SQ_W'(r_s1.mag[i]);
            end
            r_sum <= SPR_SUM_W'(r_sq[0]) + SPR_SUM_W'(r_sq[1]) + SPR_SUM_W'(r_sq[2]);
        end
    end

    // one root bit per stage, remainder kept as radicand minus root squared
    for (genvar k = 0; k < SPR_ROOT_W; k++) begin : g_root
        localparam int BI = SPR_ROOT_W - 1 - k;
        logic [SPR_SUM_W-1:0]  rem_in;
        logic [SPR_ROOT_W-1:0] root_in;
        t_fside                side_in;
        logic [TRIAL_W-1:0]    trial;
        logic                  take;

        if (k == 0) begin : g_head
            assign rem_in  = r_sum;
            assign root_in = '0;
            assign side_in = r_s3;
        end else begin : g_tail
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_qs[k-1];
        end

        assign trial = (TRIAL_W'(root_in) << (BI + 1)) | (TRIAL_W'(1) << (2 * BI));
        assign take  = TRIAL_W'(rem_in) >= trial;

        always_ff @(posedge i_clk) begin
            if (f_en) begin
                r_rem[k]  <= take ? rem_in - trial[SPR_SUM_W-1:0] : rem_in;
                r_root[k] <= take ? (root_in | (SPR_ROOT_W'(1) << BI)) : root_in;
                r_qs[k]   <= side_in;
            end
        end
    end

    always_comb begin
        logic wzero;
        wzero           = (r_qs[LAST].wa == '0) && (r_qs[LAST].wb == '0);
        o_q_job.a       = r_qs[LAST].a;
        o_q_job.b       = r_qs[LAST].b;
        o_q_job.neg     = r_qs[LAST].neg;
        o_q_job.mag     = r_qs[LAST].mag;
        o_q_job.wa      = r_qs[LAST].wa;
        o_q_job.wb      = r_qs[LAST].wb;
        o_q_job.cdist   = r_root[LAST];
        o_q_job.hit     = r_root[LAST] < SPR_ROOT_W'(r_qs[LAST].rsum);
        o_q_job.over    = r_qs[LAST].rsum - r_root[LAST][SPR_RSUM_W-1:0];
        o_q_job.werr    = o_q_job.hit && wzero;
        o_q_job.move    = o_q_job.hit && !wzero && (r_root[LAST] != '0);
    end

    assign o_q_push = r_qv[LAST] && !i_q_full;

    a_hold_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qv[LAST] && i_q_full |=> r_qv[LAST] && $stable(r_root[LAST]))
        else $error("blocked item left the front");

endmodule

// ===== design/spr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_back
// Push-back execution: weight split, per-axis scaling by the distance,
// sign, saturation and the output register.
// ----------------------------------------------------------------------------
module spr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  spr_pkg::t_job i_q_job,
    output logic          o_q_pop,
    spr_out_if.source     o_res
);
    import spr_pkg::*;

    localparam int QW = SPR_QUO_W;

    logic                      b_en;
    logic                      r_v1;
    t_job                      r_j1;
    logic [SPR_AMT_NUM_W-1:0]  r_num_a;
    logic [SPR_AMT_NUM_W-1:0]  r_num_b;
    logic [SPR_WSUM_W-1:0]     r_wsum;
    logic [QW-1:0]             amt_a;
    logic [QW-1:0]             amt_b;
    logic [QW-1:0]             r_dv1;
    t_job                      r_dj1 [QW];
    logic                      r_v2;
    t_job                      r_j2;
    logic [SPR_AXIS_NUM_W-1:0] r_mp_a [3];
    logic [SPR_AXIS_NUM_W-1:0] r_mp_b [3];
    logic [QW-1:0]             quo_a [3];
    logic [QW-1:0]             quo_b [3];
    logic [QW-1:0]             r_dv2;
    t_job                      r_dj2 [QW];
    logic                      r_out_valid;
    t_coord                    r_na [3];
    t_coord                    r_nb [3];
    logic                      r_hit;
    logic                      r_werr;
    t_coord                    n_na [3];
    t_coord                    n_nb [3];

    assign b_en    = !r_out_valid || o_res.ready;
    assign o_q_pop = b_en && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_dv1       <= '0;
            r_v2        <= 1'b0;
            r_dv2       <= '0;
            r_out_valid <= 1'b0;
        end else if (b_en) begin
            r_v1        <= o_q_pop;
            r_dv1       <= {r_dv1[QW-2:0], r_v1};
            r_v2        <= r_dv1[QW-1];
            r_dv2       <= {r_dv2[QW-2:0], r_v2};
            r_out_valid <= r_dv2[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_j1    <= i_q_job;
            r_num_a <= SPR_AMT_NUM_W'(i_q_job.over) * SPR_AMT_NUM_W'(i_q_job.wb);
            r_num_b <= SPR_AMT_NUM_W'(i_q_job.over) * SPR_AMT_NUM_W'(i_q_job.wa);
            r_wsum  <= SPR_WSUM_W'(i_q_job.wa) + SPR_WSUM_W'(i_q_job.wb);
            r_dj1[0] <= r_j1;
            for (int s = 1; s < QW; s++) begin
                r_dj1[s] <= r_dj1[s-1];
            end
            r_j2 <= r_dj1[QW-1];
            for (int i = 0; i < 3; i++) begin
                r_mp_a[i] <= SPR_AXIS_NUM_W'(r_dj1[QW-1].mag[i]) * SPR_AXIS_NUM_W'(amt_a);
                r_mp_b[i] <= SPR_AXIS_NUM_W'(r_dj1[QW-1].mag[i]) * SPR_AXIS_NUM_W'(amt_b);
            end
            r_dj2[0] <= r_j2;
            for (int s = 1; s < QW; s++) begin
                r_dj2[s] <= r_dj2[s-1];
            end
            r_na   <= n_na;
            r_nb   <= n_nb;
            r_hit  <= r_dj2[QW-1].hit;
            r_werr <= r_dj2[QW-1].werr;
        end
    end

    // move amounts: overlap split by the other sphere's weight
    spr_div #(.NUM_W(SPR_AMT_NUM_W), .DEN_W(SPR_WSUM_W), .QUO_W(QW)) u_amt_a (
        .i_clk (i_clk), .i_en (b_en), .i_num (r_num_a), .i_den (r_wsum), .o_quo (amt_a)
    );
    spr_div #(.NUM_W(SPR_AMT_NUM_W), .DEN_W(SPR_WSUM_W), .QUO_W(QW)) u_amt_b (
        .i_clk (i_clk), .i_en (b_en), .i_num (r_num_b), .i_den (r_wsum), .o_quo (amt_b)
    );

    // per-axis share of the move along the unit vector
    for (genvar i = 0; i < 3; i++) begin : g_axis
        spr_div #(.NUM_W(SPR_AXIS_NUM_W), .DEN_W(SPR_ROOT_W), .QUO_W(QW)) u_pa (
            .i_clk (i_clk), .i_en (b_en), .i_num (r_mp_a[i]), .i_den (r_j2.cdist),
            .o_quo (quo_a[i])
        );
        spr_div #(.NUM_W(SPR_AXIS_NUM_W), .DEN_W(SPR_ROOT_W), .QUO_W(QW)) u_pb (
            .i_clk (i_clk), .i_en (b_en), .i_num (r_mp_b[i]), .i_den (r_j2.cdist),
            .o_quo (quo_b[i])
        );
    end

    always_comb begin
        logic signed [SPR_COORD_W+1:0] ea;
        logic signed [SPR_COORD_W+1:0] eb;
        logic signed [SPR_COORD_W+1:0] pa;
        logic signed [SPR_COORD_W+1:0] pb;
        for (int i = 0; i < 3; i++) begin
            ea = $signed({{2{r_dj2[QW-1].a[i][SPR_COORD_W-1]}}, r_dj2[QW-1].a[i]});
            eb = $signed({{2{r_dj2[QW-1].b[i][SPR_COORD_W-1]}}, r_dj2[QW-1].b[i]});
            pa = $signed({2'b00, quo_a[i]});
            pb = $signed({2'b00, quo_b[i]});
            if (r_dj2[QW-1].neg[i]) begin
                pa = -pa;
                pb = -pb;
            end
            if (r_dj2[QW-1].move) begin
                n_na[i] = spr_sat(ea + pa);
                n_nb[i] = spr_sat(eb - pb);
            end else begin
                n_na[i] = r_dj2[QW-1].a[i];
                n_nb[i] = r_dj2[QW-1].b[i];
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.new_a_x      = r_na[0];
    assign o_res.new_a_y      = r_na[1];
    assign o_res.new_a_z      = r_na[2];
    assign o_res.new_b_x      = r_nb[0];
    assign o_res.new_b_y      = r_nb[1];
    assign o_res.new_b_z      = r_nb[2];
    assign o_res.hit          = r_hit;
    assign o_res.weight_error = r_werr;

    a_werr_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_werr |-> r_hit)
        else $error("weight error without hit");
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |=> $stable(r_dv2) && $stable(r_dv1) && r_out_valid)
        else $error("back pipeline moved while output stalled");

endmodule
